// ----- rtl/pcc_pkg.sv -----
// Shared types and constants of the per-id call counter hash table.
`default_nettype none

package pcc_pkg;

   localparam int TABLE_SIZE_DEF = 64;

   localparam int ID_W     = 32;
   localparam int OPND_W   = 16;
   localparam int SLOT_W   = 6;
   localparam int SQ_W     = 30;
   localparam int CNT_W    = 32;
   localparam int STATUS_W = 2;

   // secondary hash: step = (ident mod STEP_MOD) + 1
   localparam int STEP_MOD = 13;
   localparam int STEP_W   = 4;
   localparam int R13_W    = 4;

   // remainder unit takes DIG_BITS key bits a cycle
   localparam int DIG_BITS = 4;
   localparam int DIGITS   = ID_W / DIG_BITS;
   localparam int DIG_W    = $clog2(DIGITS);

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_NEGATIVE  = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CALL   = 1'b1;

   typedef struct packed {
      logic key_we;
      logic cnt_we;
   } mem_we_type;

endpackage : pcc_pkg

`default_nettype wire

// ----- rtl/pcc_mem.sv -----
// Key and count storage: two synchronous arrays, one write and one read port.
`default_nettype none

module pcc_mem #(
   parameter int TABLE_SIZE = pcc_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W = $clog2(TABLE_SIZE)
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [IDX_W-1:0]           rd_addr,
   output logic      [pcc_pkg::ID_W-1:0]   key_rd,
   output logic      [pcc_pkg::CNT_W-1:0]  cnt_rd,
   input  wire pcc_pkg::mem_we_type        we,
   input  wire logic [IDX_W-1:0]           wr_addr,
   input  wire logic [pcc_pkg::ID_W-1:0]   wr_key,
   input  wire logic [pcc_pkg::CNT_W-1:0]  wr_cnt
);

   logic [pcc_pkg::ID_W-1:0]  key_mem [TABLE_SIZE];
   logic [pcc_pkg::CNT_W-1:0] cnt_mem [TABLE_SIZE];
   logic [pcc_pkg::ID_W-1:0]  key_rd_ff;
   logic [pcc_pkg::CNT_W-1:0] cnt_rd_ff;

   always_ff @(posedge clock) begin
      if (we.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (we.cnt_we) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         cnt_rd_ff <= cnt_mem[rd_addr];
      end
   end

   assign key_rd = key_rd_ff;
   assign cnt_rd = cnt_rd_ff;

endmodule : pcc_mem

`default_nettype wire

// ----- rtl/pcc_hash.sv -----
// Home slot and probe step of a key: ident mod table size and (ident mod 13) + 1.
`default_nettype none

module pcc_hash #(
   parameter int TABLE_SIZE = pcc_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W = $clog2(TABLE_SIZE)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pcc_pkg::ID_W-1:0]      ident,
   output logic                               done,
   output logic      [IDX_W-1:0]              pos,
   output logic      [pcc_pkg::STEP_W-1:0]    step
);

   localparam int RW = IDX_W + 1;

   logic [pcc_pkg::ID_W-1:0]  shift_ff;
   logic [IDX_W-1:0]          rt_ff, rt_in;
   logic [pcc_pkg::R13_W-1:0] r13_ff, r13_in;
   logic [pcc_pkg::DIG_W-1:0] dig_ff;
   logic                      busy_ff;
   logic                      done_ff;

   // restoring remainder, MSB first, DIG_BITS bits a cycle
   always_comb begin
      logic [RW-1:0]               rt_w;
      logic [pcc_pkg::R13_W:0]     r13_w;
      logic                        b;
      rt_in  = rt_ff;
      r13_in = r13_ff;
      for (int k = 0; k < pcc_pkg::DIG_BITS; k++) begin
         b    = shift_ff[pcc_pkg::ID_W-1-k];
         rt_w = {rt_in, b};
         if (rt_w >= RW'(TABLE_SIZE)) begin
            rt_w = rt_w - RW'(TABLE_SIZE);
         end
         rt_in = rt_w[IDX_W-1:0];
         r13_w = {r13_in, b};
         if (r13_w >= (pcc_pkg::R13_W+1)'(pcc_pkg::STEP_MOD)) begin
            r13_w = r13_w - (pcc_pkg::R13_W+1)'(pcc_pkg::STEP_MOD);
         end
         r13_in = r13_w[pcc_pkg::R13_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         dig_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            dig_ff  <= '0;
         end else if (busy_ff) begin
            dig_ff <= dig_ff + 1'b1;
            if (dig_ff == pcc_pkg::DIG_W'(pcc_pkg::DIGITS-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= ident;
         rt_ff    <= '0;
         r13_ff   <= '0;
      end else if (busy_ff) begin
         shift_ff <= shift_ff << pcc_pkg::DIG_BITS;
         rt_ff    <= rt_in;
         r13_ff   <= r13_in;
      end
   end

   assign done = done_ff;
   assign pos  = rt_ff;
   assign step = pcc_pkg::STEP_W'(r13_ff) + 1'b1;

endmodule : pcc_hash

`default_nettype wire

// ----- rtl/per_id_call_counter_hash_table.sv -----
// Top level of the per-id call counter: probe sequencer, update and result register.
//
// Request channel (req_): one transfer per command. req_tuser is the operation
// (0 insert identifier, 1 record square call); req_tdata carries ident and
// operand_n. Response channel (rsp_): exactly one transfer per request with
// slot, square_value and call_count in rsp_tdata and the status in rsp_tuser.
// Keys live in an open-addressed table (one synchronous key/count memory).
// Each command with a nonzero ident is first run through a remainder unit (4 key
// bits a cycle) to get the home slot and the probe step, then probes one slot per
// cycle through the memory read port until a match or a full pass.
// The next request is taken in the cycle after the result moves to the output
// register. A zero ident skips the remainder unit and the walk and is answered
// as not found. Commands are processed one at a time; a finished response
// waits in the output register while the next request is already accepted and
// worked on; only the hand-off of the following response stalls if rsp_tready
// stays low. Reset starts a clearing pass that writes every slot empty, one
// slot a cycle, with req_tready low.
`default_nettype none

module per_id_call_counter_hash_table #(
   parameter int TABLE_SIZE = pcc_pkg::TABLE_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [31:0] ident, [47:32] operand_n
   input  wire logic        req_tuser,   // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,   // [5:0] slot, [35:6] square_value,
                                         // [67:36] call_count, [71:68] zero
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IDX_W = $clog2(TABLE_SIZE);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [STATE_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [STATE_W-1:0] ST_HASH   = 3'd2;
   localparam logic [STATE_W-1:0] ST_PROBE  = 3'd3;
   localparam logic [STATE_W-1:0] ST_CALC   = 3'd4;
   localparam logic [STATE_W-1:0] ST_FINISH = 3'd5;

   logic [STATE_W-1:0] state_ff, state_in;

   // latched command
   logic                               op_ff;
   logic [pcc_pkg::ID_W-1:0]           ident_ff;
   logic [pcc_pkg::OPND_W-1:0]         opnd_ff;

   // probe walk
   logic [IDX_W-1:0]                   pos_ff, pos_in;
   logic [pcc_pkg::STEP_W-1:0]         step_ff;
   logic [IDX_W-1:0]                   pcnt_ff;
   logic [IDX_W-1:0]                   clr_ff;
   logic [pcc_pkg::CNT_W-1:0]          hit_cnt_ff;

   // finished result, then output register
   logic [pcc_pkg::SLOT_W-1:0]         res_slot_ff;
   logic [pcc_pkg::SQ_W-1:0]           res_sq_ff;
   logic [pcc_pkg::CNT_W-1:0]          res_cnt_ff;
   pcc_pkg::status_type                res_status_ff;
   logic                               rsp_valid_ff;
   logic [pcc_pkg::SLOT_W-1:0]         rsp_slot_ff;
   logic [pcc_pkg::SQ_W-1:0]           rsp_sq_ff;
   logic [pcc_pkg::CNT_W-1:0]          rsp_cnt_ff;
   pcc_pkg::status_type                rsp_status_ff;

   logic                               req_xfer;
   logic                               req_nz;
   logic                               hash_done;
   logic [IDX_W-1:0]                   hash_pos;
   logic [pcc_pkg::STEP_W-1:0]         hash_step;
   logic                               rd_en;
   logic [pcc_pkg::ID_W-1:0]           key_rd;
   logic [pcc_pkg::CNT_W-1:0]          cnt_rd;
   pcc_pkg::mem_we_type                mem_we;
   logic [IDX_W-1:0]                   wr_addr;
   logic [pcc_pkg::ID_W-1:0]           wr_key;
   logic [pcc_pkg::CNT_W-1:0]          wr_cnt;
   logic [pcc_pkg::ID_W-1:0]           want_key;
   logic                               hit;
   logic [IDX_W:0]                     pos_sum;
   logic [IDX_W-1:0]                   pos_next;
   logic [pcc_pkg::CNT_W:0]            cnt_sum;
   logic [pcc_pkg::CNT_W-1:0]          cnt_sat;
   logic                               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_nz     = (req_tdata[31:0] != '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   pcc_hash #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (req_xfer && req_nz),
      .ident (req_tdata[31:0]),
      .done  (hash_done),
      .pos   (hash_pos),
      .step  (hash_step)
   );

   // next probe slot; step < TABLE_SIZE so one subtract wraps it
   assign pos_sum  = {1'b0, pos_ff} + (IDX_W+1)'(step_ff);
   assign pos_next = (pos_sum >= (IDX_W+1)'(TABLE_SIZE))
                     ? IDX_W'(pos_sum - (IDX_W+1)'(TABLE_SIZE)) : pos_sum[IDX_W-1:0];

   // insert looks for an empty slot, call for its own key
   assign want_key = (op_ff == pcc_pkg::OP_INSERT) ? '0 : ident_ff;
   assign hit      = (key_rd == want_key);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      rd_en    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(TABLE_SIZE-1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = req_nz ? ST_HASH : ST_FINISH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               pos_in   = hash_pos;
               rd_en    = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (hit) begin
               state_in = ST_CALC;
            end else if (pcnt_ff == IDX_W'(TABLE_SIZE-1)) begin
               state_in = ST_FINISH;
            end else begin
               pos_in = pos_next;
               rd_en  = 1'b1;
            end
         end
         ST_CALC: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // saturating count update: count + n + 1
   assign cnt_sum = {1'b0, hit_cnt_ff} + (pcc_pkg::CNT_W+1)'(opnd_ff) + 1'b1;
   assign cnt_sat = cnt_sum[pcc_pkg::CNT_W] ? '1 : cnt_sum[pcc_pkg::CNT_W-1:0];

   always_comb begin
      mem_we  = '0;
      wr_addr = pos_ff;
      wr_key  = ident_ff;
      wr_cnt  = cnt_sat;
      if (state_ff == ST_CLEAR) begin
         mem_we.key_we = 1'b1;
         mem_we.cnt_we = 1'b1;
         wr_addr       = clr_ff;
         wr_key        = '0;
         wr_cnt        = '0;
      end else if (state_ff == ST_CALC) begin
         if (op_ff == pcc_pkg::OP_INSERT) begin
            mem_we.key_we = 1'b1;
            mem_we.cnt_we = 1'b1;
            wr_cnt        = '0;
         end else if (!opnd_ff[pcc_pkg::OPND_W-1]) begin
            mem_we.cnt_we = 1'b1;
         end
      end
   end

   pcc_mem #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (pos_in),
      .key_rd  (key_rd),
      .cnt_rd  (cnt_rd),
      .we      (mem_we),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_cnt  (wr_cnt)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff         <= req_tuser;
         ident_ff      <= req_tdata[31:0];
         opnd_ff       <= req_tdata[47:32];
         // a zero ident answers as not found
         res_slot_ff   <= '0;
         res_sq_ff     <= '0;
         res_cnt_ff    <= '0;
         res_status_ff <= pcc_pkg::STATUS_NOT_FOUND;
      end
      pos_ff <= pos_in;
      if (state_ff == ST_HASH) begin
         step_ff <= hash_step;
         pcnt_ff <= '0;
      end else if (state_ff == ST_PROBE) begin
         pcnt_ff <= pcnt_ff + 1'b1;
         if (hit) begin
            hit_cnt_ff <= cnt_rd;
         end
      end
      if (state_ff == ST_CALC) begin
         res_slot_ff <= pcc_pkg::SLOT_W'(pos_ff);
         if (op_ff == pcc_pkg::OP_INSERT) begin
            res_sq_ff     <= '0;
            res_cnt_ff    <= '0;
            res_status_ff <= pcc_pkg::STATUS_OK;
         end else if (opnd_ff[pcc_pkg::OPND_W-1]) begin
            res_sq_ff     <= '0;
            res_cnt_ff    <= hit_cnt_ff;
            res_status_ff <= pcc_pkg::STATUS_NEGATIVE;
         end else begin
            res_sq_ff     <= opnd_ff[pcc_pkg::OPND_W-2:0] * opnd_ff[pcc_pkg::OPND_W-2:0];
            res_cnt_ff    <= cnt_sat;
            res_status_ff <= pcc_pkg::STATUS_OK;
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_sq_ff     <= res_sq_ff;
         rsp_cnt_ff    <= res_cnt_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_cnt_ff, rsp_sq_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // memory is written only by the clearing pass or the update step
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      (mem_we.key_we || mem_we.cnt_we) |-> (state_ff == ST_CLEAR || state_ff == ST_CALC))
      else $error("table write outside clear or update");

   // an accepted request goes to the hash unit or straight to the answer
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_HASH || state_ff == ST_FINISH))
      else $error("bad state after request transfer");

   // a not-found answer carries no slot and no count
   a_nf_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == pcc_pkg::STATUS_NOT_FOUND)
         |-> (rsp_slot_ff == '0 && rsp_cnt_ff == '0 && rsp_sq_ff == '0))
      else $error("not-found response with payload");

   // a negative operand never yields a square
   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == pcc_pkg::STATUS_NEGATIVE) |-> (rsp_sq_ff == '0))
      else $error("negative operand with nonzero square");

   // the remainder unit reports only while the sequencer waits for it
   a_hash_wait: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH))
      else $error("hash result outside hash wait");

endmodule : per_id_call_counter_hash_table

`default_nettype wire

// ----- test/per_id_call_counter_hash_table_test.sv -----
// Self-checking testbench of the per-id call counter hash table.
module per_id_call_counter_hash_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = pcc_pkg::TABLE_SIZE_DEF;
   localparam int RANDOM_ITEMS = 600;
   localparam int MAX_REPORTS  = 10;
   localparam int LONG_STALL   = 300;   // receiver hold-off, in cycles
   localparam int STALL_AT     = 100;   // random item that triggers the hold-off
   localparam int DRAIN_CYCLES = 100;   // idle wait after the last expected response

   // one response as the block reports it
   typedef struct packed {
      logic [pcc_pkg::SLOT_W-1:0] slot;
      logic [pcc_pkg::SQ_W-1:0]   square;
      logic [pcc_pkg::CNT_W-1:0]  count;
      pcc_pkg::status_type        status;
   } answer_type;

   // one directed command; typed rows carry their answer written out
   typedef struct {
      logic                       op;
      logic [pcc_pkg::ID_W-1:0]   ident;
      logic [pcc_pkg::OPND_W-1:0] operand;
      bit                         typed;
      answer_type                 answer;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // [31:0] ident, [47:32] operand_n
   logic        req_tuser = 1'b0;  // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [5:0] slot, [35:6] square_value, [67:36] call_count
   logic [1:0]  rsp_tuser;         // [1:0] status

   // mirror of the block's key and count memories
   logic [pcc_pkg::ID_W-1:0]  mirror_keys   [SLOTS];
   logic [pcc_pkg::CNT_W-1:0] mirror_counts [SLOTS];

   answer_type               pending_answers[$];  // predicted responses, oldest first
   logic [pcc_pkg::ID_W-1:0] stored_ids[$];       // keys inserted so far (duplicates too)
   directed_row_type         directed_plan[$];

   int idle_phase    = 0;   // 0: sender 34 / receiver 86, 1: swapped, 2: no idling
   bit stall_request = 1'b0;
   int mismatches    = 0;

   per_id_call_counter_hash_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop well past the slowest legal run
   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic bit chance(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_phase)
         0: return 34;
         1: return 86;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_phase)
         0: return 86;
         1: return 34;
         default: return 0;
      endcase
   endfunction

   function automatic answer_type answer(int slot, int square,
                                         logic [pcc_pkg::CNT_W-1:0] count,
                                         pcc_pkg::status_type status);
      answer_type a;
      a.slot   = pcc_pkg::SLOT_W'(slot);
      a.square = pcc_pkg::SQ_W'(square);
      a.count  = count;
      a.status = status;
      return a;
   endfunction

   // Double-hash probe: home = ident mod SLOTS, step = (ident mod 13) + 1.
   // Up to a full pass of SLOTS probes, stopping at the first match; even steps revisit slots.
   function automatic bit probe_mirror(logic [pcc_pkg::ID_W-1:0] ident,
                                       logic [pcc_pkg::ID_W-1:0] want,
                                       output int where);
      int pos;
      int stride;
      pos    = int'(ident % SLOTS);
      stride = int'(ident % pcc_pkg::STEP_MOD) + 1;
      where  = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (mirror_keys[pos] == want) begin
            where = pos;
            return 1'b1;
         end
         pos = (pos + stride) % SLOTS;
      end
      return 1'b0;
   endfunction

   // Applies one command to the mirror and returns the response it must give.
   function automatic answer_type apply_command(logic op, logic [pcc_pkg::ID_W-1:0] ident,
                                                logic [pcc_pkg::OPND_W-1:0] operand);
      answer_type  a;
      int          where;
      logic [32:0] sum;
      logic [29:0] magnitude;
      a = answer(0, 0, '0, pcc_pkg::STATUS_NOT_FOUND);
      // zero ident never matches anything: answered as not found
      if (ident != '0) begin
         if (op == pcc_pkg::OP_INSERT) begin
            if (probe_mirror(ident, '0, where)) begin
               mirror_keys[where]   = ident;
               mirror_counts[where] = '0;
               a = answer(where, 0, '0, pcc_pkg::STATUS_OK);
            end
         end else if (probe_mirror(ident, ident, where)) begin
            if (operand[pcc_pkg::OPND_W-1]) begin
               // negative operand: count reported but untouched
               a = answer(where, 0, mirror_counts[where], pcc_pkg::STATUS_NEGATIVE);
            end else begin
               // one count per recursion level of the square, saturating
               sum = {1'b0, mirror_counts[where]} + 33'(operand) + 33'd1;
               if (sum[32]) begin
                  sum = {1'b0, {pcc_pkg::CNT_W{1'b1}}};
               end
               mirror_counts[where] = sum[pcc_pkg::CNT_W-1:0];
               magnitude = {15'd0, operand[14:0]};
               a.slot   = pcc_pkg::SLOT_W'(where);
               a.square = magnitude * magnitude;
               a.count  = sum[pcc_pkg::CNT_W-1:0];
               a.status = pcc_pkg::STATUS_OK;
            end
         end
      end
      return a;
   endfunction

   function automatic void add_row(logic op, logic [pcc_pkg::ID_W-1:0] ident,
                                   logic [pcc_pkg::OPND_W-1:0] operand, bit typed,
                                   answer_type ans);
      directed_row_type row;
      row.op      = op;
      row.ident   = ident;
      row.operand = operand;
      row.typed   = typed;
      row.answer  = ans;
      directed_plan.push_back(row);
   endfunction

   // Offers one command from the falling edge on and holds it until the transfer.
   task automatic send_command(input logic op, input logic [pcc_pkg::ID_W-1:0] ident,
                               input logic [pcc_pkg::OPND_W-1:0] operand, input bit typed,
                               input answer_type typed_answer);
      answer_type predicted;
      @(negedge clock);
      while (chance(sender_idle_pct())) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {operand, ident};
      do @(posedge clock); while (!req_tready);
      predicted = apply_command(op, ident, operand);
      pending_answers.push_back(typed ? typed_answer : predicted);
      if (op == pcc_pkg::OP_INSERT && predicted.status == pcc_pkg::STATUS_OK) begin
         stored_ids.push_back(ident);
      end
   endtask

   // Receiver: random back-pressure per phase, plus one long hold-off on request.
   initial begin
      int holdoff;
      holdoff = 0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            holdoff       = LONG_STALL;
            stall_request = 1'b0;
         end
         if (holdoff > 0) begin
            holdoff--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !chance(receiver_idle_pct());
         end
      end
   end

   // Response checker: every transfer against the oldest prediction.
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slot   = rsp_tdata[5:0];
         got.square = rsp_tdata[35:6];
         got.count  = rsp_tdata[67:36];
         got.status = rsp_tuser;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected response: slot %0d square %0d count %0d status %0d",
                        got.slot, got.square, got.count, got.status);
            end
         end else begin
            want = pending_answers.pop_front();
            if (got.slot !== want.slot || got.square !== want.square ||
                got.count !== want.count || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("mismatch: expected slot %0d square %0d count %0d status %0d",
                           want.slot, want.square, want.count, want.status);
                  $display("          actual   slot %0d square %0d count %0d status %0d",
                           got.slot, got.square, got.count, got.status);
               end
            end
         end
      end
   end

   initial begin
      int                         counted;
      int                         pick;
      int                         flavor;
      logic                       op;
      logic [pcc_pkg::ID_W-1:0]   ident;
      logic [pcc_pkg::OPND_W-1:0] operand;
      bit                         stall_given;

      for (int i = 0; i < SLOTS; i++) begin
         mirror_keys[i]   = '0;
         mirror_counts[i] = '0;
      end

      // empty table: lookups miss, zero ident is ignored
      add_row(pcc_pkg::OP_CALL,   32'd5,  16'd3, 1'b1,
              answer(0, 0, '0, pcc_pkg::STATUS_NOT_FOUND));
      add_row(pcc_pkg::OP_INSERT, 32'd0,  16'd0, 1'b1,
              answer(0, 0, '0, pcc_pkg::STATUS_NOT_FOUND));
      add_row(pcc_pkg::OP_CALL,   32'd0,  16'd7, 1'b1,
              answer(0, 0, '0, pcc_pkg::STATUS_NOT_FOUND));
      // largest ident lands in the top slot; operand extremes
      add_row(pcc_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'd0, 1'b1,
              answer(63, 0, '0, pcc_pkg::STATUS_OK));
      add_row(pcc_pkg::OP_CALL,   32'hFFFF_FFFF, 16'h7FFF, 1'b1,
              answer(63, 1073676289, 32'd32768, pcc_pkg::STATUS_OK));
      add_row(pcc_pkg::OP_CALL,   32'hFFFF_FFFF, 16'hFFFF, 1'b1,
              answer(63, 0, 32'd32768, pcc_pkg::STATUS_NEGATIVE));
      add_row(pcc_pkg::OP_CALL,   32'hFFFF_FFFF, 16'h8000, 1'b1,
              answer(63, 0, 32'd32768, pcc_pkg::STATUS_NEGATIVE));
      add_row(pcc_pkg::OP_CALL,   32'hFFFF_FFFF, 16'd0, 1'b1,
              answer(63, 0, 32'd32769, pcc_pkg::STATUS_OK));
      add_row(pcc_pkg::OP_INSERT, 32'd1, 16'd0, 1'b1, answer(1, 0, '0, pcc_pkg::STATUS_OK));
      add_row(pcc_pkg::OP_CALL,   32'd1, 16'd1, 1'b0, '0);
      // duplicate key goes to the next free slot, calls still hit the first copy
      add_row(pcc_pkg::OP_INSERT, 32'd1, 16'd0, 1'b0, '0);
      add_row(pcc_pkg::OP_CALL,   32'd1, 16'd2, 1'b0, '0);
      // 65 collides with 1 at home slot 1
      add_row(pcc_pkg::OP_INSERT, 32'd65, 16'd0, 1'b0, '0);
      add_row(pcc_pkg::OP_CALL,   32'd65, 16'd100, 1'b0, '0);
      // missing key with a negative operand: not found takes priority
      add_row(pcc_pkg::OP_CALL,   32'd129, 16'hFFFB, 1'b1,
              answer(0, 0, '0, pcc_pkg::STATUS_NOT_FOUND));
      add_row(pcc_pkg::OP_INSERT, 32'd64, 16'd0, 1'b0, '0);
      add_row(pcc_pkg::OP_CALL,   32'd64, 16'd9, 1'b0, '0);
      // even stride: probe sequence revisits slots
      add_row(pcc_pkg::OP_INSERT, 32'h8000_0000, 16'd0, 1'b0, '0);
      add_row(pcc_pkg::OP_CALL,   32'h8000_0000, 16'h5555, 1'b0, '0);
      add_row(pcc_pkg::OP_INSERT, 32'hAAAA_AAAA, 16'd0, 1'b0, '0);
      add_row(pcc_pkg::OP_CALL,   32'hAAAA_AAAA, 16'h2AAA, 1'b0, '0);
      add_row(pcc_pkg::OP_INSERT, 32'h5555_5555, 16'd0, 1'b0, '0);
      add_row(pcc_pkg::OP_CALL,   32'h5555_5555, 16'h1234, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the clearing pass after reset just shows up as req_tready low
      foreach (directed_plan[i]) begin
         send_command(directed_plan[i].op, directed_plan[i].ident, directed_plan[i].operand,
                      directed_plan[i].typed, directed_plan[i].answer);
      end

      // sender pause: let every directed response drain
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);

      // Random traffic: mostly calls on stored keys, some inserts (the table fills
      // up and later inserts answer not found), misses and ignored zero idents.
      counted     = 0;
      stall_given = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (counted < RANDOM_ITEMS / 3) begin
            idle_phase = 0;
         end else if (counted < 2 * RANDOM_ITEMS / 3) begin
            idle_phase = 1;
         end else begin
            idle_phase = 2;
         end
         if (counted == STALL_AT && !stall_given) begin
            // receiver stops while commands keep coming
            stall_request = 1'b1;
            stall_given   = 1'b1;
         end

         flavor = $urandom_range(0, 99);
         if (flavor < 60) begin
            operand = pcc_pkg::OPND_W'($urandom_range(0, 32767));
         end else if (flavor < 75) begin
            operand = pcc_pkg::OPND_W'($urandom_range(0, 15));
         end else begin
            operand = pcc_pkg::OPND_W'($urandom);
         end

         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            op     = pcc_pkg::OP_INSERT;
            flavor = $urandom_range(0, 99);
            if (flavor < 70) begin
               ident = $urandom;
            end else if (flavor < 90) begin
               ident = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
            end else begin
               // clustered keys to force collisions
               ident = pcc_pkg::ID_W'($urandom_range(1, 63) + SLOTS * $urandom_range(0, 15));
            end
         end else if (pick < 82) begin
            op    = pcc_pkg::OP_CALL;
            ident = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
         end else if (pick < 94) begin
            op    = pcc_pkg::OP_CALL;
            ident = $urandom;
         end else begin
            op    = logic'($urandom_range(0, 1));
            ident = '0;
         end

         send_command(op, ident, operand, 1'b0, '0);
         if (ident != '0) begin
            counted++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
